>>> rtl/cwbp_pkg.sv
// Package for the codeword bit packer.
// Holds widths, table sizes, request codes, controller states and the
// command and status structs between controller and datapath.
package cwbp_pkg;

  // Longest codeword kept; longer loads are clamped to this length
  localparam int MAX_CODE_LEN = 32;

  // Field widths
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  // Shifter counters: room left in a byte (1..8) and bits filled (0..7)
  localparam int CNT_W = $clog2(BYTE_W + 1);
  localparam int FIL_W = $clog2(BYTE_W);

  // Code table
  localparam int TABLE_DEPTH = 256;
  localparam int ENTRY_W     = CODE_W + LEN_W;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_PACK,
    ST_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic write_entry;  // store a table entry from the input item
    logic lookup;       // start the table read for a data item
    logic load_code;    // take the read codeword into the shifter
    logic step;         // append one chunk of code bits
    logic emit_flush;   // send the padded partial byte
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rem_zero;       // no code bits left for this item
    logic byte_done;      // the next chunk completes a byte
    logic flush_pending;  // final item with a partly filled byte
    logic slot_free;      // output register can take a byte
  } status_t;

endpackage

>>> rtl/cwbp_item_if.sv
// Input channel of the codeword bit packer.
// Valid/ready handshake with the item fields; widths from cwbp_pkg.
interface cwbp_item_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [cwbp_pkg::SYM_W-1:0]   symbol;
  logic [cwbp_pkg::CODE_W-1:0]  code_bits;
  logic [cwbp_pkg::LEN_W-1:0]   code_len;
  logic                         flush;

  modport source (
    output valid, req_type, symbol, code_bits, code_len, flush,
    input  ready
  );
  modport sink (
    input  valid, req_type, symbol, code_bits, code_len, flush,
    output ready
  );
endinterface

>>> rtl/cwbp_result_if.sv
// Output channel of the codeword bit packer.
// Valid/ready handshake with the result fields; widths from cwbp_pkg.
interface cwbp_result_if;
  logic                         valid;
  logic                         ready;
  logic [cwbp_pkg::BYTE_W-1:0]  packed_byte;
  logic                         last_in_run;
  logic                         stream_end;

  modport source (
    output valid, packed_byte, last_in_run, stream_end,
    input  ready
  );
  modport sink (
    input  valid, packed_byte, last_in_run, stream_end,
    output ready
  );
endinterface

>>> rtl/cwbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package dependency.
module cwbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cwbp_ctrl.sv
// Controller of the codeword bit packer: item handshake and sequencing.
// Uses cwbp_pkg for states and the command/status structs.
module cwbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_req_type,
  input  cwbp_pkg::status_t status,
  output logic              item_ready,
  output cwbp_pkg::cmd_t    cmd
);

  cwbp_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cwbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cwbp_pkg::ST_IDLE: begin
        if (item_valid && item_req_type == cwbp_pkg::REQ_DATA) begin
          state_next = cwbp_pkg::ST_LOOKUP;
        end
      end
      cwbp_pkg::ST_LOOKUP: begin
        state_next = cwbp_pkg::ST_PACK;
      end
      cwbp_pkg::ST_PACK: begin
        if (status.rem_zero) begin
          state_next = status.flush_pending ? cwbp_pkg::ST_FLUSH : cwbp_pkg::ST_IDLE;
        end
      end
      cwbp_pkg::ST_FLUSH: begin
        if (status.slot_free) begin
          state_next = cwbp_pkg::ST_IDLE;
        end
      end
      default: state_next = cwbp_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      cwbp_pkg::ST_IDLE: begin
        item_ready      = 1'b1;
        cmd.write_entry = item_valid && item_req_type == cwbp_pkg::REQ_LOAD;
        cmd.lookup      = item_valid && item_req_type == cwbp_pkg::REQ_DATA;
      end
      cwbp_pkg::ST_LOOKUP: begin
        cmd.load_code = 1'b1;
      end
      cwbp_pkg::ST_PACK: begin
        // a chunk that fills a byte waits for room in the output register
        cmd.step = !status.rem_zero && (!status.byte_done || status.slot_free);
      end
      cwbp_pkg::ST_FLUSH: begin
        cmd.emit_flush = status.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/cwbp_dp.sv
// Datapath of the codeword bit packer: code table, bit shifter, partial
// byte and output register. Uses cwbp_pkg, cwbp_ram and the result channel interface.
module cwbp_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cwbp_pkg::SYM_W-1:0]    symbol,
  input  logic [cwbp_pkg::CODE_W-1:0]   code_bits,
  input  logic [cwbp_pkg::LEN_W-1:0]    code_len,
  input  logic                          flush,
  input  cwbp_pkg::cmd_t                cmd,
  output cwbp_pkg::status_t             status,
  cwbp_result_if.source                 result
);

  // Table entry valid bits; an entry never loaded reads as zero length
  logic [cwbp_pkg::TABLE_DEPTH-1:0] entry_valid;
  logic [cwbp_pkg::LEN_W-1:0]       len_clamped;
  logic [cwbp_pkg::ENTRY_W-1:0]     rd_entry;
  logic                             rd_valid;
  logic                             flush_q;

  // Shifter state
  logic [cwbp_pkg::CODE_W-1:0]  code_reg;
  logic [cwbp_pkg::LEN_W-1:0]   rem;
  logic [cwbp_pkg::BYTE_W-1:0]  partial_byte;
  logic [cwbp_pkg::FIL_W-1:0]   bits_filled;

  // Chunk math
  logic [cwbp_pkg::CNT_W-1:0]   room;
  logic [cwbp_pkg::CNT_W-1:0]   take;
  logic [cwbp_pkg::LEN_W-1:0]   shift_amt;
  logic [cwbp_pkg::CODE_W-1:0]  shifted;
  logic [cwbp_pkg::BYTE_W-1:0]  chunk_mask;
  logic [cwbp_pkg::BYTE_W-1:0]  placed;
  logic [cwbp_pkg::BYTE_W-1:0]  byte_new;
  logic                         byte_done;
  logic                         emit_step;

  // Output register
  logic                        out_valid;
  logic [cwbp_pkg::BYTE_W-1:0] out_byte;
  logic                        out_last;
  logic                        out_end;
  logic                        slot_free;

  // Clamp the load length to the longest supported codeword
  always_comb begin
    if ({1'b0, code_len} > (cwbp_pkg::LEN_W + 1)'(cwbp_pkg::MAX_CODE_LEN)) begin
      len_clamped = cwbp_pkg::LEN_W'(cwbp_pkg::MAX_CODE_LEN);
    end else begin
      len_clamped = code_len;
    end
  end

  cwbp_ram #(
    .WIDTH (cwbp_pkg::ENTRY_W),
    .DEPTH (cwbp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.write_entry),
    .waddr (symbol),
    .wdata ({code_bits, len_clamped}),
    .raddr (symbol),
    .rdata (rd_entry)
  );

  // Valid bits and per-item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.write_entry) begin
      entry_valid[symbol] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rd_valid <= entry_valid[symbol];
      flush_q  <= flush;
    end
  end

  // Chunk: take bits up to the next byte boundary or the end of the code
  always_comb begin
    room       = cwbp_pkg::CNT_W'(cwbp_pkg::BYTE_W) - cwbp_pkg::CNT_W'(bits_filled);
    take       = ({{(cwbp_pkg::LEN_W - cwbp_pkg::CNT_W){1'b0}}, room} > rem)
                 ? cwbp_pkg::CNT_W'(rem) : room;
    shift_amt  = rem - cwbp_pkg::LEN_W'(take);
    shifted    = code_reg >> shift_amt;
    chunk_mask = cwbp_pkg::BYTE_W'(((cwbp_pkg::BYTE_W + 1)'(1) << take)
                 - (cwbp_pkg::BYTE_W + 1)'(1));
    placed     = (shifted[cwbp_pkg::BYTE_W-1:0] & chunk_mask) << (room - take);
    byte_new   = partial_byte | placed;
    byte_done  = (take == room);
  end

  assign emit_step = cmd.step && byte_done;
  assign slot_free = !out_valid || result.ready;

  // Codeword and remaining length
  always_ff @(posedge clk) begin
    if (cmd.load_code) begin
      code_reg <= rd_entry[cwbp_pkg::ENTRY_W-1:cwbp_pkg::LEN_W];
      rem      <= rd_valid ? rd_entry[cwbp_pkg::LEN_W-1:0] : '0;
    end else if (cmd.step) begin
      rem      <= shift_amt;
    end
  end

  // Partial byte, kept across items until full or flushed
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte <= '0;
      bits_filled  <= '0;
    end else if (cmd.emit_flush) begin
      partial_byte <= '0;
      bits_filled  <= '0;
    end else if (cmd.step) begin
      partial_byte <= byte_done ? '0 : byte_new;
      bits_filled  <= bits_filled + cwbp_pkg::FIL_W'(take);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_step || cmd.emit_flush) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_flush) begin
      out_byte <= partial_byte;
      out_last <= 1'b1;
      out_end  <= 1'b1;
    end else if (emit_step) begin
      // a full byte ends the item when no further byte, full or padded, follows
      out_byte <= byte_new;
      out_last <= (shift_amt < cwbp_pkg::LEN_W'(cwbp_pkg::BYTE_W))
                  && !(flush_q && shift_amt != '0);
      out_end  <= 1'b0;
    end
  end

  assign result.valid       = out_valid;
  assign result.packed_byte = out_byte;
  assign result.last_in_run = out_last;
  assign result.stream_end  = out_end;

  // Status to controller
  assign status.rem_zero      = (rem == '0);
  assign status.byte_done     = byte_done;
  assign status.flush_pending = flush_q && (bits_filled != '0);
  assign status.slot_free     = slot_free;

endmodule

>>> rtl/codeword_bit_packer.sv
// Top level of the codeword bit packer: controller plus datapath.
// Depends on cwbp_pkg, cwbp_item_if, cwbp_result_if, cwbp_ctrl, cwbp_dp.
//
//   channel  role    transfer carries
//   -------  ------  ----------------------------------------------------
//   item     sink    req_type, symbol, code_bits, code_len, flush
//   result   source  packed_byte, last_in_run, stream_end
//
// A load item writes the 256-entry table RAM. A data item is accepted, read
// from the RAM, shifted out in steps of up to 8 bits each (a step ends at a
// byte boundary or at the end of the code), and finished; with flush set, a
// partly filled byte is then sent as a padded flush byte.
// Reset clears the table valid bits, partial byte and output register at once.
// A full output register stalls the shifter on a step that completes a byte
// and holds the flush byte.
module codeword_bit_packer (
  input  logic        clk,
  input  logic        rst,
  cwbp_item_if.sink   item,
  cwbp_result_if.source result
);

  cwbp_pkg::cmd_t    cmd;
  cwbp_pkg::status_t status;

  cwbp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item.valid),
    .item_req_type (item.req_type),
    .status        (status),
    .item_ready    (item.ready),
    .cmd           (cmd)
  );

  cwbp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .symbol    (item.symbol),
    .code_bits (item.code_bits),
    .code_len  (item.code_len),
    .flush     (item.flush),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule
